### hw/rtl/jsle_pkg.sv
// Shared types, character codes and helpers of the string literal escaper.
`default_nettype none

package jsle_pkg;

   typedef logic [7:0] char_type;

   // Longest run of characters one word can cause: quote, \xHH, quote
   localparam int unsigned MaxRun = 6;
   localparam int unsigned RunW   = $clog2(MaxRun + 1);

   typedef logic [RunW-1:0] run_cnt_type;
   typedef char_type [MaxRun-1:0] run_buf_type;

   localparam char_type QUOTE_CHAR  = 8'h22;
   localparam char_type BSLASH_CHAR = 8'h5C;
   localparam char_type LF_CHAR     = 8'h0A;
   localparam char_type CR_CHAR     = 8'h0D;
   localparam char_type BEL_CHAR    = 8'h07;
   localparam char_type N_CHAR      = 8'h6E;
   localparam char_type R_CHAR      = 8'h72;
   localparam char_type A_CHAR      = 8'h61;
   localparam char_type X_CHAR      = 8'h78;
   localparam char_type SPACE_CHAR  = 8'h20;
   localparam char_type DEL_CHAR    = 8'h7F;

   // Upper-case hex digit of one nibble
   function automatic char_type hex_digit(input logic [3:0] nib);
      char_type d;
      if (nib < 4'd10) begin
         d = 8'h30 + {4'h0, nib};
      end else begin
         d = 8'h37 + {4'h0, nib};
      end
      return d;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/jsle_if.sv
// Valid/ready channels carrying raw string words in and escaped characters out.
`default_nettype none

interface jsle_req_if import jsle_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type data_byte;
   logic     has_byte;
   logic     start_of_string;
   logic     end_of_string;

   modport source (output valid, output data_byte, output has_byte,
                   output start_of_string, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input start_of_string, input end_of_string, output ready);
endinterface

interface jsle_rsp_if import jsle_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type out_char;
   logic     last_of_run;

   modport source (output valid, output out_char, output last_of_run, input ready);
   modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/js_string_literal_escaper_core.sv
// Top level: escapes a byte stream into a double-quoted script string literal.
`default_nettype none

// Each request word is expanded into a run of one to six characters
// (opening quote, the byte or its escape, closing quote) and loaded into a run
// register; the response side drains that register one character per cycle while
// rsp_ch.ready is high and flags the final one with last_of_run. Plain bytes
// without quotes flow at one word per cycle while the response side is ready,
// but escapes and quotes hold req_ready low until the run drains. The next word
// is taken in the same cycle the last character of the current run is taken.
// Words that cause no character are accepted and dropped. No state survives
// between words and there is no configuration.
module js_string_literal_escaper_core import jsle_pkg::*; (
   input wire        clock,
   input wire        reset,
   jsle_req_if.sink   req_ch,
   jsle_rsp_if.source rsp_ch
);

   logic        run_vld_ff, run_vld_in;
   run_buf_type run_buf_ff, run_buf_in;
   run_cnt_type run_cnt_ff, run_cnt_in;
   run_cnt_type run_idx_ff, run_idx_in;

   run_buf_type exp_buf;
   run_cnt_type exp_cnt;
   char_type    esc_char [4];
   run_cnt_type esc_len;
   run_cnt_type pos;
   logic        is_last;
   logic        rsp_take;
   logic        req_take;

   // Build the escape sequence of the byte
   always_comb begin
      esc_char[0] = BSLASH_CHAR;
      esc_char[1] = req_ch.data_byte;
      esc_char[2] = 8'h00;
      esc_char[3] = 8'h00;
      esc_len     = run_cnt_type'(2);
      case (req_ch.data_byte)
         BSLASH_CHAR: esc_char[1] = BSLASH_CHAR;
         LF_CHAR:     esc_char[1] = N_CHAR;
         CR_CHAR:     esc_char[1] = R_CHAR;
         BEL_CHAR:    esc_char[1] = A_CHAR;
         QUOTE_CHAR:  esc_char[1] = QUOTE_CHAR;
         default: begin
            if (req_ch.data_byte < SPACE_CHAR || req_ch.data_byte > DEL_CHAR) begin
               esc_char[1] = X_CHAR;
               esc_char[2] = hex_digit(req_ch.data_byte[7:4]);
               esc_char[3] = hex_digit(req_ch.data_byte[3:0]);
               esc_len     = run_cnt_type'(4);
            end else begin
               esc_char[0] = req_ch.data_byte;
               esc_len     = run_cnt_type'(1);
            end
         end
      endcase
   end

   // Lay out quote, escape and quote into the run
   always_comb begin
      exp_buf = '0;
      pos     = '0;
      if (req_ch.start_of_string) begin
         exp_buf[0] = QUOTE_CHAR;
         pos        = run_cnt_type'(1);
      end
      if (req_ch.has_byte) begin
         for (int k = 0; k < 4; k++) begin
            if (run_cnt_type'(k) < esc_len) begin
               exp_buf[pos + run_cnt_type'(k)] = esc_char[k];
            end
         end
         pos = pos + esc_len;
      end
      if (req_ch.end_of_string) begin
         exp_buf[pos] = QUOTE_CHAR;
         pos          = pos + run_cnt_type'(1);
      end
      exp_cnt = pos;
   end

   // Handshakes: refill the run as its last character leaves
   assign is_last      = (run_idx_ff == run_cnt_ff - run_cnt_type'(1));
   assign rsp_take     = run_vld_ff && rsp_ch.ready;
   assign req_ch.ready = !run_vld_ff || (rsp_ch.ready && is_last);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = run_vld_ff;
   assign rsp_ch.out_char    = run_buf_ff[run_idx_ff];
   assign rsp_ch.last_of_run = is_last;

   // Advance through the run, or load a new one
   always_comb begin
      run_vld_in = run_vld_ff;
      run_buf_in = run_buf_ff;
      run_cnt_in = run_cnt_ff;
      run_idx_in = run_idx_ff;
      if (rsp_take) begin
         if (is_last) begin
            run_vld_in = 1'b0;
         end else begin
            run_idx_in = run_idx_ff + run_cnt_type'(1);
         end
      end
      if (req_take && exp_cnt != '0) begin
         run_vld_in = 1'b1;
         run_buf_in = exp_buf;
         run_cnt_in = exp_cnt;
         run_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_vld_ff <= 1'b0;
         run_cnt_ff <= '0;
         run_idx_ff <= '0;
      end else begin
         run_vld_ff <= run_vld_in;
         run_cnt_ff <= run_cnt_in;
         run_idx_ff <= run_idx_in;
      end
      run_buf_ff <= run_buf_in;
   end

   // A held run is never empty and never longer than the widest expansion
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      run_vld_ff |-> (run_cnt_ff != '0 && run_cnt_ff <= run_cnt_type'(MaxRun)))
      else $error("run length out of range");

   // The read pointer stays inside the run
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      run_vld_ff |-> (run_idx_ff < run_cnt_ff))
      else $error("run index past end");

   // Taking a middle character keeps the run and steps the pointer by one
   a_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !is_last) |=>
         (run_vld_ff && run_idx_ff == $past(run_idx_ff) + run_cnt_type'(1)))
      else $error("run pointer did not advance");

   // A new word is only taken when the run is empty or finishing
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!run_vld_ff || (rsp_take && is_last)))
      else $error("word taken over a pending run");

endmodule

`default_nettype wire

### test/js_string_literal_escaper_core_checker.sv
// Checker that predicts escaped characters from request words and compares responses.
module jsle_escape_checker import jsle_pkg::*; (
   input wire   clock,
   input wire   reset,
   jsle_req_if  req_ch,
   jsle_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   chars_pending
);

   typedef struct packed {
      char_type ch;
      logic     last;
   } esc_char_type;

   esc_char_type escaped_chars_q[$];
   esc_char_type oldest;

   // Upper-case hex digit for one nibble
   function automatic char_type nib_to_hex(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return char_type'(8'h30 + nib);
      end
      return char_type'(8'h41 + nib - 4'd10);
   endfunction

   // Build the run of characters one word causes and queue it
   function automatic void escape_word(input char_type b, input logic has,
                                       input logic opens, input logic closes);
      char_type run [MaxRun];
      char_type esc;
      int       n;
      n = 0;
      if (opens) begin
         run[n] = QUOTE_CHAR;
         n++;
      end
      if (has) begin
         case (b)
            BSLASH_CHAR: esc = BSLASH_CHAR;
            LF_CHAR:     esc = N_CHAR;
            CR_CHAR:     esc = R_CHAR;
            BEL_CHAR:    esc = A_CHAR;
            QUOTE_CHAR:  esc = QUOTE_CHAR;
            default:     esc = '0;
         endcase
         if (esc != '0) begin
            run[n]     = BSLASH_CHAR;
            run[n + 1] = esc;
            n += 2;
         end else if (b < SPACE_CHAR || b > DEL_CHAR) begin
            // Control and high bytes become \xHH
            run[n]     = BSLASH_CHAR;
            run[n + 1] = X_CHAR;
            run[n + 2] = nib_to_hex(b[7:4]);
            run[n + 3] = nib_to_hex(b[3:0]);
            n += 4;
         end else begin
            run[n] = b;
            n++;
         end
      end
      if (closes) begin
         run[n] = QUOTE_CHAR;
         n++;
      end
      for (int i = 0; i < n; i++) begin
         escaped_chars_q.push_back('{ch: run[i], last: (i == n - 1)});
      end
   endfunction

   // Predict on accepted request words, then compare accepted response words
   always @(posedge clock) begin
      if (reset) begin
         mismatch_count = 0;
         escaped_chars_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            escape_word(req_ch.data_byte, req_ch.has_byte,
                        req_ch.start_of_string, req_ch.end_of_string);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (escaped_chars_q.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual char %h last %b",
                        $time, rsp_ch.out_char, rsp_ch.last_of_run);
               mismatch_count++;
            end else begin
               oldest = escaped_chars_q.pop_front();
               if (oldest.ch !== rsp_ch.out_char) begin
                  $display("%0t: out_char mismatch: expected %h, actual %h",
                           $time, oldest.ch, rsp_ch.out_char);
                  mismatch_count++;
               end
               if (oldest.last !== rsp_ch.last_of_run) begin
                  $display("%0t: last_of_run mismatch: expected %b, actual %b",
                           $time, oldest.last, rsp_ch.last_of_run);
                  mismatch_count++;
               end
            end
         end
      end
      chars_pending <= escaped_chars_q.size();
   end

endmodule

### test/js_string_literal_escaper_core_tb.sv
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
module js_string_literal_escaper_core_tb;
   import jsle_pkg::*;

   logic clock;
   logic reset;
   logic rsp_ready_q = 1'b0;
   bit   calm = 1'b0;
   int   words_sent = 0;
   int   mismatch_count;
   int   chars_pending;

   jsle_req_if req_ch ();
   jsle_rsp_if rsp_ch ();

   js_string_literal_escaper_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   jsle_escape_checker esc_chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at random, except in the calm stretch
   assign rsp_ch.ready = rsp_ready_q;
   always @(posedge clock) begin
      rsp_ready_q <= calm || ($urandom_range(99) >= 9);
   end

   // Offer one word, idling first at random, and hold it until taken
   task automatic send_word(input char_type b, input logic has,
                            input logic opens, input logic closes);
      calm = (words_sent >= 50 && words_sent < 85);
      while (!calm && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.data_byte       <= b;
      req_ch.has_byte        <= has;
      req_ch.start_of_string <= opens;
      req_ch.end_of_string   <= closes;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   initial begin
      int       len;
      char_type b;
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.data_byte       = '0;
      req_ch.has_byte        = 1'b0;
      req_ch.start_of_string = 1'b0;
      req_ch.end_of_string   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty string, word with nothing to emit, lone marks
      send_word(8'hA5, 1'b0, 1'b1, 1'b1);
      send_word(8'h5A, 1'b0, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0, 1'b1);
      // Directed: extremes and every escape class, with quote combinations
      send_word(8'h00, 1'b1, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b1, 1'b1);
      send_word(DEL_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(SPACE_CHAR, 1'b1, 1'b1, 1'b0);
      send_word(8'h1F, 1'b1, 1'b0, 1'b0);
      send_word(8'h80, 1'b1, 1'b0, 1'b1);
      send_word(BSLASH_CHAR, 1'b1, 1'b1, 1'b0);
      send_word(LF_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(CR_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(BEL_CHAR, 1'b1, 1'b0, 1'b0);
      send_word(QUOTE_CHAR, 1'b1, 1'b0, 1'b1);
      send_word(8'h41, 1'b1, 1'b1, 1'b1);
      send_word(8'h7E, 1'b1, 1'b0, 1'b0);
      send_word(8'h09, 1'b1, 1'b0, 1'b0);
      send_word(8'h0F, 1'b1, 1'b1, 1'b1);
      send_word(8'hF0, 1'b1, 1'b1, 1'b1);
      send_word(8'h3A, 1'b1, 1'b0, 1'b0);

      // Random: mostly well-formed strings, some loose words
      while (words_sent < 120) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(6);
            if (len == 0) begin
               send_word(char_type'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
            end
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(9))
                  0: begin
                     case ($urandom_range(4))
                        0: b = BSLASH_CHAR;
                        1: b = LF_CHAR;
                        2: b = CR_CHAR;
                        3: b = BEL_CHAR;
                        default: b = QUOTE_CHAR;
                     endcase
                  end
                  1: b = char_type'($urandom_range(31));
                  2: b = char_type'($urandom_range(255, 128));
                  default: b = char_type'($urandom_range(127, 32));
               endcase
               send_word(b, 1'b1, (i == 0), (i == len - 1));
            end
         end else begin
            send_word(char_type'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
      req_ch.valid <= 1'b0;

      // Drain the remaining characters, then allow for latency
      @(posedge clock);
      while (chars_pending != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
